// File: rtl/ahbm_pkg.sv
// ----------------------------------------------------------------------------
// ahbm_pkg
// Types and constants shared by the adaptive histogram bin merge block.
// ----------------------------------------------------------------------------
`default_nettype none

package ahbm_pkg;

    // One histogram bin as held in the bin memory
    typedef struct packed {
        logic [30:0] lo;
        logic [30:0] hi;
        logic [31:0] cnt;
    } entry_t;

    // Result status codes
    localparam logic [2:0] STAT_COUNTED  = 3'd0;
    localparam logic [2:0] STAT_INSERTED = 3'd1;
    localparam logic [2:0] STAT_MERGED   = 3'd2;
    localparam logic [2:0] STAT_REJECTED = 3'd3;
    localparam logic [2:0] STAT_READ_OK  = 3'd4;
    localparam logic [2:0] STAT_BAD_IDX  = 3'd5;

    // Request kinds
    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Configuration register indexes
    localparam logic REG_BIN_LIMIT = 1'b0;

    localparam logic [6:0] BIN_LIMIT_RESET = 7'd100;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_PUT,
        S_SCAN,
        S_MGET,
        S_MSHIFT,
        S_FETCH,
        S_CAPT
    } state_t;

endpackage

`default_nettype wire

// File: rtl/adaptive_histogram_bin_merge.sv
// ----------------------------------------------------------------------------
// adaptive_histogram_bin_merge
// Sorted table of closed integer bins with counts, merged on overflow.
// ----------------------------------------------------------------------------
// One request is handled at a time; the bin table sits in a single memory
// with one write and one read port, and every pass walks it one entry per
// cycle. A read request goes through fetch, capture and idle; a bad index
// skips the fetch, and a negative sample goes straight to capture. With N
// the bins held, a sample takes a containment search; if it falls inside a
// bin that bin is counted, else the search and an insertion shift together
// walk the table once and a put places the new bin. When the limit is
// exceeded there follow a cost scan over the N+1 bins (one registered 31x33
// multiply per pair), a fetch and write of the merged pair and a closing
// shift, plus a fetch and capture to deliver the result.
// The result register lets the next request enter while a result waits.
`default_nettype none

module adaptive_histogram_bin_merge #(
    parameter int MAX_BINS = 128
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    // request channel
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_kind,
    input  wire logic signed [31:0] s_duration,
    input  wire logic [6:0]         s_bin_index,
    // result channel
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [2:0]              m_status,
    output logic [30:0]             m_bin_low,
    output logic [30:0]             m_bin_high,
    output logic [31:0]             m_bin_count,
    output logic [6:0]              m_bins_in_use,
    output logic [31:0]             m_total_samples,
    output logic [63:0]             m_total_sum,
    output logic [63:0]             m_total_square_sum
);

    localparam int IW = $clog2(MAX_BINS);
    localparam int CW = IW + 1;
    localparam int LW = (CW > 7) ? CW : 7;

    ahbm_pkg::state_t state_reg, state_next;

    // bin memory
    ahbm_pkg::entry_t mem [MAX_BINS];
    ahbm_pkg::entry_t rd_data_reg;
    logic [IW-1:0]    rd_addr;
    logic             we;
    logic [IW-1:0]    wa;
    ahbm_pkg::entry_t wd;

    // control and datapath registers
    logic [6:0]    bin_limit_reg;
    logic [CW-1:0] used_reg;
    logic [CW-1:0] ptr_reg;
    logic [CW-1:0] sp_reg;
    logic          issuing_reg;
    logic          pend_reg;
    logic [IW-1:0] pend_addr_reg;
    logic [IW-1:0] pos_reg;
    logic [1:0]    mc_reg;
    logic [30:0]   d_reg;
    logic          add_reg;
    logic          zero_reg;
    logic [2:0]    status_reg;
    logic [61:0]   sq_reg;

    // cost scan pipeline
    logic [30:0]   prev_lo_reg;
    logic [31:0]   prev_cnt_reg;
    logic          s1_v_reg;
    logic [IW-1:0] s1_idx_reg;
    logic [30:0]   span_reg;
    logic [32:0]   wt_reg;
    logic          s2_v_reg;
    logic [IW-1:0] s2_idx_reg;
    logic [63:0]   prod_reg;
    logic          first_reg;
    logic [63:0]   best_cost_reg;
    logic [IW-1:0] best_reg;
    ahbm_pkg::entry_t left_reg;

    // totals and result register
    logic [31:0]   samp_reg;
    logic [63:0]   sum_reg;
    logic [63:0]   sqsum_reg;
    logic          m_valid_reg;
    logic [2:0]    m_status_reg;
    logic [30:0]   m_lo_reg;
    logic [30:0]   m_hi_reg;
    logic [31:0]   m_cnt_reg;
    logic [6:0]    m_used_reg;

    // shared conditions
    logic          s_accept;
    logic          cfg_wr;
    logic [LW-1:0] lim;
    logic [CW-1:0] used_p1;
    logic          merge_need;
    logic          srch_hit;
    logic          srch_end;
    logic          srch_inside;
    logic          scan_done;
    logic          shift_done;
    logic          capt_go;
    logic          idx_ok;
    logic [CW-1:0] best_p2;
    logic [32:0]   msum;
    logic [31:0]   mcnt;
    logic [31:0]   samp_next;
    logic [64:0]   sum_wide;
    logic [64:0]   sqsum_wide;
    logic [63:0]   sum_next;
    logic [63:0]   sqsum_next;

    assign s_accept   = s_valid && s_ready;
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == ahbm_pkg::REG_BIN_LIMIT) ? {25'd0, bin_limit_reg} : 32'd0;

    // effective limit is capped at one below the table depth
    always_comb begin
        if (LW'(bin_limit_reg) > LW'(MAX_BINS - 1)) begin
            lim = LW'(MAX_BINS - 1);
        end else begin
            lim = LW'(bin_limit_reg);
        end
    end

    assign used_p1     = used_reg + CW'(1);
    assign merge_need  = (LW'(used_p1) > lim) && (used_p1 >= CW'(2));
    assign srch_hit    = pend_reg && (rd_data_reg.hi >= d_reg);
    assign srch_inside = rd_data_reg.lo <= d_reg;
    assign srch_end    = !srch_hit && (ptr_reg == used_reg);
    assign scan_done   = (ptr_reg == used_reg) && !pend_reg && !s1_v_reg && !s2_v_reg;
    assign shift_done  = !issuing_reg && !pend_reg;
    assign capt_go     = !m_valid_reg || m_ready;
    assign idx_ok      = LW'(s_bin_index) < LW'(used_reg);
    assign best_p2     = CW'(best_reg) + CW'(2);
    assign msum        = {1'b0, left_reg.cnt} + {1'b0, rd_data_reg.cnt};
    assign mcnt        = msum[32] ? 32'hFFFF_FFFF : msum[31:0];

    // saturating totals
    assign samp_next  = (samp_reg == 32'hFFFF_FFFF) ? samp_reg : samp_reg + 32'd1;
    assign sum_wide   = {1'b0, sum_reg} + 65'(d_reg);
    assign sqsum_wide = {1'b0, sqsum_reg} + 65'(sq_reg);
    assign sum_next   = sum_wide[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_wide[63:0];
    assign sqsum_next = sqsum_wide[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sqsum_wide[63:0];

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ahbm_pkg::S_IDLE: begin
                if (s_accept) begin
                    if (s_kind == ahbm_pkg::KIND_READ) begin
                        state_next = idx_ok ? ahbm_pkg::S_FETCH : ahbm_pkg::S_CAPT;
                    end else if (s_duration[31]) begin
                        state_next = ahbm_pkg::S_CAPT;
                    end else begin
                        state_next = ahbm_pkg::S_SEARCH;
                    end
                end
            end
            ahbm_pkg::S_SEARCH: begin
                if (srch_hit) begin
                    state_next = srch_inside ? ahbm_pkg::S_FETCH
                               : ahbm_pkg::S_SHIFT;
                end else if (srch_end) begin
                    state_next = ahbm_pkg::S_PUT;
                end
            end
            ahbm_pkg::S_SHIFT: begin
                if (shift_done) begin
                    state_next = ahbm_pkg::S_PUT;
                end
            end
            ahbm_pkg::S_PUT: begin
                state_next = merge_need ? ahbm_pkg::S_SCAN : ahbm_pkg::S_FETCH;
            end
            ahbm_pkg::S_SCAN: begin
                if (scan_done) begin
                    state_next = ahbm_pkg::S_MGET;
                end
            end
            ahbm_pkg::S_MGET: begin
                if (mc_reg == 2'd2) begin
                    state_next = ahbm_pkg::S_MSHIFT;
                end
            end
            ahbm_pkg::S_MSHIFT: begin
                if (shift_done) begin
                    state_next = ahbm_pkg::S_FETCH;
                end
            end
            ahbm_pkg::S_FETCH: begin
                state_next = ahbm_pkg::S_CAPT;
            end
            ahbm_pkg::S_CAPT: begin
                if (capt_go) begin
                    state_next = ahbm_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ahbm_pkg::S_IDLE;
            end
        endcase
    end

    // memory port control
    always_comb begin
        rd_addr = pos_reg;
        we      = 1'b0;
        wa      = pos_reg;
        wd      = rd_data_reg;
        s_ready = 1'b0;
        case (state_reg)
            ahbm_pkg::S_IDLE: begin
                s_ready = 1'b1;
            end
            ahbm_pkg::S_SEARCH: begin
                rd_addr = ptr_reg[IW-1:0];
                if (srch_hit && srch_inside) begin
                    we     = 1'b1;
                    wa     = pend_addr_reg;
                    wd.cnt = (rd_data_reg.cnt == 32'hFFFF_FFFF) ? rd_data_reg.cnt
                           : rd_data_reg.cnt + 32'd1;
                end
            end
            ahbm_pkg::S_SHIFT: begin
                rd_addr = sp_reg[IW-1:0];
                we      = pend_reg;
                wa      = pend_addr_reg + IW'(1);
            end
            ahbm_pkg::S_PUT: begin
                we     = 1'b1;
                wa     = pos_reg;
                wd.lo  = d_reg;
                wd.hi  = d_reg;
                wd.cnt = 32'd1;
            end
            ahbm_pkg::S_SCAN: begin
                rd_addr = ptr_reg[IW-1:0];
            end
            ahbm_pkg::S_MGET: begin
                rd_addr = (mc_reg == 2'd0) ? best_reg : best_reg + IW'(1);
                if (mc_reg == 2'd2) begin
                    we     = 1'b1;
                    wa     = best_reg;
                    wd.lo  = left_reg.lo;
                    wd.hi  = rd_data_reg.hi;
                    wd.cnt = mcnt;
                end
            end
            ahbm_pkg::S_MSHIFT: begin
                rd_addr = sp_reg[IW-1:0];
                we      = pend_reg;
                wa      = pend_addr_reg - IW'(1);
            end
            default: begin
                rd_addr = pos_reg;
            end
        endcase
    end

    // bin memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // free-running square of the held sample
    always_ff @(posedge aclk) begin
        sq_reg <= d_reg * d_reg;
    end

    // state and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ahbm_pkg::S_IDLE;
            bin_limit_reg <= ahbm_pkg::BIN_LIMIT_RESET;
            used_reg      <= '0;
            samp_reg      <= '0;
            sum_reg       <= '0;
            sqsum_reg     <= '0;
            m_valid_reg   <= 1'b0;
            pend_reg      <= 1'b0;
            issuing_reg   <= 1'b0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;

            // configuration write
            if (cfg_wr && paddr[2] == ahbm_pkg::REG_BIN_LIMIT) begin
                bin_limit_reg <= pwdata[6:0]; 
            end

            // drop the result once taken, unless a new one replaces it
            if (m_valid_reg && m_ready && state_reg != ahbm_pkg::S_CAPT) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ahbm_pkg::S_IDLE: begin
                    // capture the request
                    if (s_accept) begin
                        ptr_reg  <= '0;
                        pend_reg <= 1'b0;
                        d_reg    <= s_duration[30:0];
                        pos_reg  <= IW'(s_bin_index);
                        if (s_kind == ahbm_pkg::KIND_READ) begin
                            add_reg    <= 1'b0;
                            zero_reg   <= !idx_ok;
                            status_reg <= idx_ok ? ahbm_pkg::STAT_READ_OK
                                        : ahbm_pkg::STAT_BAD_IDX;
                        end else if (s_duration[31]) begin
                            add_reg    <= 1'b0;
                            zero_reg   <= 1'b1;
                            status_reg <= ahbm_pkg::STAT_REJECTED;
                        end else begin
                            add_reg  <= 1'b1;
                            zero_reg <= 1'b0;
                        end
                    end
                end
                ahbm_pkg::S_SEARCH: begin
                    if (srch_hit) begin
                        pos_reg  <= pend_addr_reg;
                        pend_reg <= 1'b0;
                        if (srch_inside) begin
                            status_reg <= ahbm_pkg::STAT_COUNTED;
                        end else begin
                            sp_reg      <= used_reg - CW'(1);
                            issuing_reg <= 1'b1;
                        end
                    end else if (srch_end) begin
                        pos_reg  <= used_reg[IW-1:0];
                        pend_reg <= 1'b0;
                    end else begin
                        pend_reg      <= 1'b1;
                        pend_addr_reg <= ptr_reg[IW-1:0];
                        ptr_reg       <= ptr_reg + CW'(1);
                    end
                end
                ahbm_pkg::S_SHIFT: begin
                    // walk down from the last bin, moving each one up
                    pend_reg <= issuing_reg;
                    if (issuing_reg) begin
                        pend_addr_reg <= sp_reg[IW-1:0];
                        if (sp_reg == CW'(pos_reg)) begin
                            issuing_reg <= 1'b0;
                        end else begin
                            sp_reg <= sp_reg - CW'(1);
                        end
                    end
                end
                ahbm_pkg::S_PUT: begin
                    used_reg   <= used_p1;
                    status_reg <= ahbm_pkg::STAT_INSERTED;
                    ptr_reg    <= '0;
                    pend_reg   <= 1'b0;
                    s1_v_reg   <= 1'b0;
                    s2_v_reg   <= 1'b0;
                    first_reg  <= 1'b1;
                end
                ahbm_pkg::S_SCAN: begin
                    // issue reads in order
                    if (ptr_reg != used_reg) begin
                        pend_reg      <= 1'b1;
                        pend_addr_reg <= ptr_reg[IW-1:0];
                        ptr_reg       <= ptr_reg + CW'(1);
                    end else begin
                        pend_reg <= 1'b0;
                    end
                    // span and weight of the pair ending at this entry
                    s1_v_reg <= pend_reg && (pend_addr_reg != '0);
                    if (pend_reg) begin
                        prev_lo_reg  <= rd_data_reg.lo;
                        prev_cnt_reg <= rd_data_reg.cnt;
                        s1_idx_reg   <= pend_addr_reg - IW'(1);
                        span_reg     <= rd_data_reg.hi - prev_lo_reg;
                        wt_reg       <= {1'b0, prev_cnt_reg} + {1'b0, rd_data_reg.cnt};
                    end
                    // cost product
                    s2_v_reg   <= s1_v_reg;
                    s2_idx_reg <= s1_idx_reg;
                    prod_reg   <= span_reg * wt_reg;
                    // keep the leftmost least cost
                    if (s2_v_reg && (first_reg || prod_reg < best_cost_reg)) begin
                        first_reg     <= 1'b0;
                        best_cost_reg <= prod_reg;
                        best_reg      <= s2_idx_reg;
                    end
                    if (scan_done) begin
                        mc_reg <= 2'd0;
                    end
                end
                ahbm_pkg::S_MGET: begin
                    mc_reg <= mc_reg + 2'd1;
                    if (mc_reg == 2'd1) begin
                        left_reg <= rd_data_reg;
                    end
                    if (mc_reg == 2'd2) begin
                        status_reg  <= ahbm_pkg::STAT_MERGED;
                        sp_reg      <= best_p2;
                        issuing_reg <= best_p2 < used_reg;
                        pend_reg    <= 1'b0;
                    end
                end
                ahbm_pkg::S_MSHIFT: begin
                    // walk up past the merged pair, moving each bin down
                    pend_reg <= issuing_reg;
                    if (issuing_reg) begin
                        pend_addr_reg <= sp_reg[IW-1:0];
                        if (sp_reg == used_reg - CW'(1)) begin
                            issuing_reg <= 1'b0;
                        end else begin
                            sp_reg <= sp_reg + CW'(1);
                        end
                    end
                    if (shift_done) begin
                        used_reg <= used_reg - CW'(1);
                        if (pos_reg > best_reg) begin
                            pos_reg <= pos_reg - IW'(1);
                        end
                    end
                end
                ahbm_pkg::S_CAPT: begin
                    if (capt_go) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= status_reg;
                        m_used_reg   <= 7'(used_reg);
                        if (zero_reg) begin
                            m_lo_reg  <= '0;
                            m_hi_reg  <= '0;
                            m_cnt_reg <= '0;
                        end else begin
                            m_lo_reg  <= rd_data_reg.lo;
                            m_hi_reg  <= rd_data_reg.hi;
                            m_cnt_reg <= rd_data_reg.cnt;
                        end
                        if (add_reg) begin
                            samp_reg  <= samp_next;
                            sum_reg   <= sum_next;
                            sqsum_reg <= sqsum_next;
                        end
                    end
                end
                default: begin
                    pend_reg <= pend_reg;
                end
            endcase
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = m_status_reg;
    assign m_bin_low          = m_lo_reg;
    assign m_bin_high         = m_hi_reg;
    assign m_bin_count        = m_cnt_reg;
    assign m_bins_in_use      = m_used_reg;
    assign m_total_samples    = samp_reg;
    assign m_total_sum        = sum_reg;
    assign m_total_square_sum = sqsum_reg;

endmodule

`default_nettype wire
